// ----- rtl/ppt_pkg.sv -----
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared constants, command and status types for the polyline proximity test.
// ----------------------------------------------------------------------------
package ppt_pkg;

   localparam int COORD_BITS_DEFAULT = 24;
   localparam int THRESH_BITS        = 48;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 48'd12800;
   localparam int DIGIT_BITS         = 16;

   // Product pairs of the small multiplier, in issue order.
   typedef enum logic [2:0] {
      PAIR_DX_SX,
      PAIR_DY_SY,
      PAIR_SX_SX,
      PAIR_SY_SY,
      PAIR_DX_SY,
      PAIR_DY_SX
   } ppt_pair_type;

   typedef struct packed {
      logic         load;
      logic         diff;
      logic         small_mul;
      ppt_pair_type mul_pair;
      logic         small_acc;
      ppt_pair_type acc_pair;
      logic         wide_load;
      logic         wide_rhs;
      logic         wide_step;
      logic         store_lhs;
      logic         decide;
      logic         commit;
      logic         emit;
   } ppt_cmd_type;

   typedef struct packed {
      logic chain_start;
      logic last;
      logic out_blocked;
   } ppt_status_type;

   // Digit steps of the wide multiplier for a given coordinate width.
   function automatic int ppt_wide_digits(input int coord_bits);
      int a_bits;
      int b_bits;
      a_bits = 2 * coord_bits + 1;
      b_bits = (a_bits > THRESH_BITS) ? a_bits : THRESH_BITS;
      return (b_bits + DIGIT_BITS - 1) / DIGIT_BITS;
   endfunction

endpackage

// ----- rtl/ppt_wide_mul.sv -----
// ----------------------------------------------------------------------------
// ppt_wide_mul
// Unsigned digit-serial multiplier, most significant multiplier digit first.
// ----------------------------------------------------------------------------
module ppt_wide_mul #(
   parameter int A_BITS = 49,
   parameter int B_BITS = 49
) (
   input  logic                clock,
   input  logic                load,
   input  logic                step,
   input  logic [A_BITS-1:0]   a_in,
   input  logic [B_BITS-1:0]   b_in,
   output logic [A_BITS+((B_BITS+ppt_pkg::DIGIT_BITS-1)/ppt_pkg::DIGIT_BITS)
                *ppt_pkg::DIGIT_BITS-1:0] product
);
   import ppt_pkg::*;

   localparam int NDIG  = (B_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int B_PAD = NDIG * DIGIT_BITS;
   localparam int RW    = A_BITS + B_PAD;
   localparam int PPW   = A_BITS + DIGIT_BITS;

   logic [A_BITS-1:0]     a_ff;
   logic [B_PAD-1:0]      b_ff;
   logic [RW-1:0]         acc_ff;
   logic [DIGIT_BITS-1:0] digit;
   logic [PPW-1:0]        partial;

   assign digit   = b_ff[B_PAD-1 -: DIGIT_BITS];
   assign partial = PPW'(a_ff) * PPW'(digit);
   assign product = acc_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff   <= a_in;
         b_ff   <= B_PAD'(b_in);
         acc_ff <= '0;
      end else if (step) begin
         acc_ff <= (acc_ff << DIGIT_BITS) + RW'(partial);
         b_ff   <= b_ff << DIGIT_BITS;
      end
   end

endmodule

// ----- rtl/ppt_datapath.sv -----
// ----------------------------------------------------------------------------
// ppt_datapath
// Vertex capture, segment products, division-free distance test, result
// register and threshold register.
// ----------------------------------------------------------------------------
module ppt_datapath #(
   parameter int COORD_BITS = ppt_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ppt_pkg::ppt_cmd_type          cmd,
   output ppt_pkg::ppt_status_type       status,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_vertex_x,
   input  logic signed [COORD_BITS-1:0]  req_vertex_y,
   input  logic                          req_chain_start,
   input  logic                          req_last_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_near,
   input  logic                          csr_write_enable,
   input  logic [ppt_pkg::THRESH_BITS-1:0] csr_write_data
);
   import ppt_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int DW   = CW + 1;
   localparam int PW   = 2 * CW + 2;
   localparam int AW   = 2 * CW + 1;
   localparam int BW   = (AW > THRESH_BITS) ? AW : THRESH_BITS;
   localparam int NDIG = (BW + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int RW   = AW + NDIG * DIGIT_BITS;

   logic [THRESH_BITS-1:0] thresh_ff;
   logic signed [CW-1:0]   px_ff, py_ff, vx_ff, vy_ff;
   logic signed [CW-1:0]   prev_x_ff, prev_y_ff;
   logic                   start_ff, last_ff;
   logic signed [DW-1:0]   dx_ff, dy_ff, sx_ff, sy_ff;
   logic signed [PW-1:0]   prod_ff;
   logic signed [PW-1:0]   c_ff, z_ff, x_ff;
   logic [RW-1:0]          lhs_ff;
   logic                   hit_ff, hit_seen_ff;
   logic                   rsp_valid_ff, rsp_is_near_ff;

   logic signed [DW-1:0]   mul_a, mul_b;
   logic signed [PW-1:0]   small_prod;
   logic signed [PW-1:0]   x_abs;
   logic [AW-1:0]          wide_a;
   logic [BW-1:0]          wide_b;
   logic [RW-1:0]          wide_prod;
   logic                   geometry_ok;

   always_comb begin
      unique case (cmd.mul_pair)
         PAIR_DX_SX: begin mul_a = dx_ff; mul_b = sx_ff; end
         PAIR_DY_SY: begin mul_a = dy_ff; mul_b = sy_ff; end
         PAIR_SX_SX: begin mul_a = sx_ff; mul_b = sx_ff; end
         PAIR_SY_SY: begin mul_a = sy_ff; mul_b = sy_ff; end
         PAIR_DX_SY: begin mul_a = dx_ff; mul_b = sy_ff; end
         PAIR_DY_SX: begin mul_a = dy_ff; mul_b = sx_ff; end
         default:    begin mul_a = '0;    mul_b = '0;    end
      endcase
   end

   assign small_prod = PW'(mul_a) * PW'(mul_b);

   // |d|^2*Z - C^2 equals the squared cross product, so only its magnitude is needed
   assign x_abs  = x_ff[PW-1] ? -x_ff : x_ff;
   assign wide_a = cmd.wide_rhs ? z_ff[AW-1:0] : x_abs[AW-1:0];
   assign wide_b = cmd.wide_rhs ? BW'(thresh_ff) : BW'(x_abs[AW-1:0]);

   ppt_wide_mul #(
      .A_BITS (AW),
      .B_BITS (BW)
   ) u_wide_mul (
      .clock   (clock),
      .load    (cmd.wide_load),
      .step    (cmd.wide_step),
      .a_in    (wide_a),
      .b_in    (wide_b),
      .product (wide_prod)
   );

   // Projection must fall on a segment of nonzero length
   assign geometry_ok = (z_ff != '0) && !c_ff[PW-1] && (c_ff <= z_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff      <= THRESH_RESET;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         hit_seen_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            thresh_ff <= csr_write_data;
         end
         if (cmd.commit) begin
            prev_x_ff   <= vx_ff;
            prev_y_ff   <= vy_ff;
            hit_seen_ff <= last_ff ? 1'b0 : (hit_seen_ff | hit_ff);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff    <= req_point_x;
         py_ff    <= req_point_y;
         vx_ff    <= req_vertex_x;
         vy_ff    <= req_vertex_y;
         start_ff <= req_chain_start;
         last_ff  <= req_last_vertex;
      end
      if (cmd.diff) begin
         dx_ff  <= DW'(px_ff) - DW'(prev_x_ff);
         dy_ff  <= DW'(py_ff) - DW'(prev_y_ff);
         sx_ff  <= DW'(vx_ff) - DW'(prev_x_ff);
         sy_ff  <= DW'(vy_ff) - DW'(prev_y_ff);
         hit_ff <= 1'b0;
      end
      if (cmd.small_mul) begin
         prod_ff <= small_prod;
      end
      if (cmd.small_acc) begin
         unique case (cmd.acc_pair)
            PAIR_DX_SX: c_ff <= prod_ff;
            PAIR_DY_SY: c_ff <= c_ff + prod_ff;
            PAIR_SX_SX: z_ff <= prod_ff;
            PAIR_SY_SY: z_ff <= z_ff + prod_ff;
            PAIR_DX_SY: x_ff <= prod_ff;
            PAIR_DY_SX: x_ff <= x_ff - prod_ff;
            default:    x_ff <= x_ff;
         endcase
      end
      if (cmd.store_lhs) begin
         lhs_ff <= wide_prod;
      end
      if (cmd.decide) begin
         hit_ff <= geometry_ok && (lhs_ff < wide_prod);
      end
      if (cmd.emit) begin
         rsp_is_near_ff <= hit_seen_ff | hit_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_near        = rsp_is_near_ff;
   assign status.chain_start = start_ff;
   assign status.last        = last_ff;
   assign status.out_blocked = rsp_valid_ff & rsp_stall;

endmodule

// ----- rtl/ppt_controller.sv -----
// ----------------------------------------------------------------------------
// ppt_controller
// Sequencer for one vertex: capture, differences, six small products, two
// digit-serial wide products, decision and commit; chain-start skips to commit.
// ----------------------------------------------------------------------------
module ppt_controller #(
   parameter int COORD_BITS = ppt_pkg::COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output ppt_pkg::ppt_cmd_type    cmd,
   input  ppt_pkg::ppt_status_type status
);
   import ppt_pkg::*;

   localparam int NDIG       = ppt_wide_digits(COORD_BITS);
   localparam int SMALL_LAST = 6;
   localparam int CNT_MAX    = (NDIG > SMALL_LAST) ? NDIG : SMALL_LAST;
   localparam int CNT_BITS   = $clog2(CNT_MAX + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SMALL,
      ST_WIDE_LHS,
      ST_WIDE_RHS,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  acc_idx;

   assign acc_idx = cnt_ff - CNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            cnt_in   = '0;
            state_in = status.chain_start ? ST_FINISH : ST_SMALL;
         end
         ST_SMALL: begin
            // product of one pair is registered, the previous one accumulated
            if (cnt_ff < CNT_BITS'(SMALL_LAST)) begin
               cmd.small_mul = 1'b1;
               cmd.mul_pair  = ppt_pair_type'(cnt_ff[2:0]);
            end
            if (cnt_ff != '0) begin
               cmd.small_acc = 1'b1;
               cmd.acc_pair  = ppt_pair_type'(acc_idx[2:0]);
            end
            if (cnt_ff == CNT_BITS'(SMALL_LAST)) begin
               cnt_in   = '0;
               state_in = ST_WIDE_LHS;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_WIDE_LHS: begin
            if (cnt_ff == '0) begin
               cmd.wide_load = 1'b1;
            end else begin
               cmd.wide_step = 1'b1;
            end
            if (cnt_ff == CNT_BITS'(NDIG)) begin
               cnt_in   = '0;
               state_in = ST_WIDE_RHS;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_WIDE_RHS: begin
            cmd.wide_rhs = 1'b1;
            if (cnt_ff == '0) begin
               cmd.wide_load = 1'b1;
               cmd.store_lhs = 1'b1;
            end else begin
               cmd.wide_step = 1'b1;
            end
            if (cnt_ff == CNT_BITS'(NDIG)) begin
               cnt_in   = '0;
               state_in = ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // a last vertex holds while the previous result is still waiting for transfer
            if (!(status.last && status.out_blocked)) begin
               cmd.commit = 1'b1;
               cmd.emit   = status.last;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/polyline_proximity_test_unit.sv -----
// ----------------------------------------------------------------------------
// polyline_proximity_test_unit
// Tests whether a query point lies within a squared distance of a polyline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (req_): one vertex per transfer with the query point and
//   chain_start / last_vertex flags. Each vertex not starting a chain closes
//   a segment with the vertex before it. Result channel (rsp_): one is_near
//   bit per polyline, issued after the vertex flagged last_vertex.
//   csr_write_data is taken into the threshold when csr_write_enable is high;
//   write it only while the block is idle.
// Sequence:
//   A segment vertex runs the differences, six small products and two wide
//   products of D = ceil(max(2*COORD_BITS+1, 48) / 16) digit steps each on the
//   shared 16-bit digit-serial multiplier, then decision and commit. A
//   chain-start vertex goes from the differences to commit. The next vertex is
//   accepted after commit; the result appears in the cycle after the last one commits.
// Reset:
//   Synchronous; clears the previous vertex, the hit flag and the result
//   valid flag, and sets the threshold to 12800 in squared coordinate units.
// Stall:
//   A pending result is held in the output register; the next polyline is
//   processed meanwhile, and only its last vertex waits for that transfer.
// ----------------------------------------------------------------------------
module polyline_proximity_test_unit #(
   parameter int COORD_BITS = ppt_pkg::COORD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [COORD_BITS-1:0]    req_point_x,
   input  logic signed [COORD_BITS-1:0]    req_point_y,
   input  logic signed [COORD_BITS-1:0]    req_vertex_x,
   input  logic signed [COORD_BITS-1:0]    req_vertex_y,
   input  logic                            req_chain_start,
   input  logic                            req_last_vertex,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_is_near,
   input  logic                            csr_write_enable,
   input  logic [ppt_pkg::THRESH_BITS-1:0] csr_write_data
);
   import ppt_pkg::*;

   ppt_cmd_type    cmd;
   ppt_status_type status;

   ppt_controller #(
      .COORD_BITS (COORD_BITS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ppt_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_chain_start  (req_chain_start),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_near      (rsp_is_near),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule
